[hdl/tcw_pkg.sv]
// Package for the text console writer: screen geometry, microcode field codes,
// the control word type and the microprogram itself. No dependencies.
`default_nettype none

package tcw_pkg;

  // Screen geometry and field widths
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int ADDR_W     = 11;
  localparam int BYTE_W     = 8;
  localparam int CELL_W     = 16;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h07;

  // Request codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Microcode field widths
  localparam int UPC_W   = 5;
  localparam int COND_W  = 4;
  localparam int MEMOP_W = 3;
  localparam int RDOP_W  = 2;
  localparam int CUROP_W = 3;
  localparam int CNTOP_W = 2;

  // Sequencer conditions: jump to target when true, else step on
  localparam logic [COND_W-1:0] J_NEXT        = 4'd0;
  localparam logic [COND_W-1:0] J_ALWAYS      = 4'd1;
  localparam logic [COND_W-1:0] J_ACCEPT      = 4'd2;  // stay until a transfer, then dispatch
  localparam logic [COND_W-1:0] J_WAIT_OUT    = 4'd3;  // stay while the result register is held
  localparam logic [COND_W-1:0] J_IF_NL       = 4'd4;
  localparam logic [COND_W-1:0] J_IF_BS       = 4'd5;
  localparam logic [COND_W-1:0] J_IF_NOT_LAST = 4'd6;
  localparam logic [COND_W-1:0] J_IF_NOT_BOT  = 4'd7;
  localparam logic [COND_W-1:0] J_IF_COPY_MORE  = 4'd8;
  localparam logic [COND_W-1:0] J_IF_SWEEP_MORE = 4'd9;
  localparam logic [COND_W-1:0] J_IF_ORIGIN   = 4'd10;

  // Memory write operations
  localparam logic [MEMOP_W-1:0] MW_NONE      = 3'd0;
  localparam logic [MEMOP_W-1:0] MW_CHAR_CUR  = 3'd1;
  localparam logic [MEMOP_W-1:0] MW_SPACE_CUR = 3'd2;
  localparam logic [MEMOP_W-1:0] MW_COPY_CNT  = 3'd3;
  localparam logic [MEMOP_W-1:0] MW_BLANK_CNT = 3'd4;
  localparam logic [MEMOP_W-1:0] MW_RESET_CNT = 3'd5;

  // Memory read operations
  localparam logic [RDOP_W-1:0] RD_NONE     = 2'd0;
  localparam logic [RDOP_W-1:0] RD_INDEX    = 2'd1;
  localparam logic [RDOP_W-1:0] RD_CNT_ROW  = 2'd2;

  // Cursor operations
  localparam logic [CUROP_W-1:0] CUR_NONE     = 3'd0;
  localparam logic [CUROP_W-1:0] CUR_HOME     = 3'd1;
  localparam logic [CUROP_W-1:0] CUR_INC      = 3'd2;
  localparam logic [CUROP_W-1:0] CUR_NEXT_ROW = 3'd3;
  localparam logic [CUROP_W-1:0] CUR_COL0     = 3'd4;
  localparam logic [CUROP_W-1:0] CUR_BACK     = 3'd5;

  // Sweep counter operations
  localparam logic [CNTOP_W-1:0] CNT_HOLD  = 2'd0;
  localparam logic [CNTOP_W-1:0] CNT_CLEAR = 2'd1;
  localparam logic [CNTOP_W-1:0] CNT_INC   = 2'd2;

  // Microprogram addresses
  localparam logic [UPC_W-1:0] U_IDLE     = 5'd0;
  localparam logic [UPC_W-1:0] U_PUT      = 5'd1;
  localparam logic [UPC_W-1:0] U_PUT_BS   = 5'd2;
  localparam logic [UPC_W-1:0] U_PUT_CHR  = 5'd3;
  localparam logic [UPC_W-1:0] U_NL       = 5'd4;
  localparam logic [UPC_W-1:0] U_SCROLL   = 5'd5;
  localparam logic [UPC_W-1:0] U_SC_RD    = 5'd6;
  localparam logic [UPC_W-1:0] U_SC_WR    = 5'd7;
  localparam logic [UPC_W-1:0] U_SC_BL    = 5'd8;
  localparam logic [UPC_W-1:0] U_DONE     = 5'd9;
  localparam logic [UPC_W-1:0] U_READ     = 5'd10;
  localparam logic [UPC_W-1:0] U_ADV      = 5'd11;
  localparam logic [UPC_W-1:0] U_NL_ADV   = 5'd12;
  localparam logic [UPC_W-1:0] U_BS       = 5'd13;
  localparam logic [UPC_W-1:0] U_BS_BACK  = 5'd14;
  localparam logic [UPC_W-1:0] U_BS_WR    = 5'd15;
  localparam logic [UPC_W-1:0] U_CLR      = 5'd16;
  localparam logic [UPC_W-1:0] U_CLR_WR   = 5'd17;
  localparam logic [UPC_W-1:0] U_CLR_END  = 5'd18;
  localparam logic [UPC_W-1:0] U_RST      = 5'd19;
  localparam logic [UPC_W-1:0] U_RST_END  = 5'd20;

  typedef struct packed {
    logic [COND_W-1:0]  cond;
    logic [UPC_W-1:0]   target;
    logic [MEMOP_W-1:0] mem_op;
    logic [RDOP_W-1:0]  rd_op;
    logic [CUROP_W-1:0] cur_op;
    logic [CNTOP_W-1:0] cnt_op;
    logic               out_load;
  } ucode_t;

  function automatic ucode_t uword(input logic [COND_W-1:0] cond,
                                   input logic [UPC_W-1:0] target,
                                   input logic [MEMOP_W-1:0] mem_op,
                                   input logic [RDOP_W-1:0] rd_op,
                                   input logic [CUROP_W-1:0] cur_op,
                                   input logic [CNTOP_W-1:0] cnt_op,
                                   input logic out_load);
    ucode_t w;
    w.cond     = cond;
    w.target   = target;
    w.mem_op   = mem_op;
    w.rd_op    = rd_op;
    w.cur_op   = cur_op;
    w.cnt_op   = cnt_op;
    w.out_load = out_load;
    return w;
  endfunction

  // The microprogram
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    unique case (upc)
      U_IDLE:    w = uword(J_ACCEPT, U_IDLE, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
      U_PUT:     w = uword(J_IF_NL, U_NL, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
      U_PUT_BS:  w = uword(J_IF_BS, U_BS, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
      U_PUT_CHR: w = uword(J_IF_NOT_LAST, U_ADV, MW_CHAR_CUR, RD_NONE, CUR_NONE,
                           CNT_HOLD, 1'b0);
      U_NL:      w = uword(J_IF_NOT_BOT, U_NL_ADV, MW_NONE, RD_NONE, CUR_NONE,
                           CNT_HOLD, 1'b0);
      U_SCROLL:  w = uword(J_NEXT, U_IDLE, MW_NONE, RD_NONE, CUR_COL0, CNT_CLEAR, 1'b0);
      U_SC_RD:   w = uword(J_NEXT, U_IDLE, MW_NONE, RD_CNT_ROW, CUR_NONE, CNT_HOLD, 1'b0);
      U_SC_WR:   w = uword(J_IF_COPY_MORE, U_SC_RD, MW_COPY_CNT, RD_NONE, CUR_NONE,
                           CNT_INC, 1'b0);
      U_SC_BL:   w = uword(J_IF_SWEEP_MORE, U_SC_BL, MW_BLANK_CNT, RD_NONE, CUR_NONE,
                           CNT_INC, 1'b0);
      U_DONE:    w = uword(J_WAIT_OUT, U_IDLE, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b1);
      U_READ:    w = uword(J_ALWAYS, U_DONE, MW_NONE, RD_INDEX, CUR_NONE, CNT_HOLD, 1'b0);
      U_ADV:     w = uword(J_ALWAYS, U_DONE, MW_NONE, RD_NONE, CUR_INC, CNT_HOLD, 1'b0);
      U_NL_ADV:  w = uword(J_ALWAYS, U_DONE, MW_NONE, RD_NONE, CUR_NEXT_ROW, CNT_HOLD,
                           1'b0);
      U_BS:      w = uword(J_IF_ORIGIN, U_DONE, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
      U_BS_BACK: w = uword(J_NEXT, U_IDLE, MW_NONE, RD_NONE, CUR_BACK, CNT_HOLD, 1'b0);
      U_BS_WR:   w = uword(J_ALWAYS, U_DONE, MW_SPACE_CUR, RD_NONE, CUR_NONE, CNT_HOLD,
                           1'b0);
      U_CLR:     w = uword(J_NEXT, U_IDLE, MW_NONE, RD_NONE, CUR_HOME, CNT_CLEAR, 1'b0);
      U_CLR_WR:  w = uword(J_IF_SWEEP_MORE, U_CLR_WR, MW_BLANK_CNT, RD_NONE, CUR_NONE,
                           CNT_INC, 1'b0);
      U_CLR_END: w = uword(J_ALWAYS, U_DONE, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
      U_RST:     w = uword(J_IF_SWEEP_MORE, U_RST, MW_RESET_CNT, RD_NONE, CUR_NONE,
                           CNT_INC, 1'b0);
      U_RST_END: w = uword(J_ALWAYS, U_IDLE, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
      default:   w = uword(J_ALWAYS, U_IDLE, MW_NONE, RD_NONE, CUR_NONE, CNT_HOLD, 1'b0);
    endcase
    return w;
  endfunction

  // Entry point of each request routine
  function automatic logic [UPC_W-1:0] dispatch(input logic [1:0] func);
    logic [UPC_W-1:0] a;
    unique case (func)
      FUNC_PUT:   a = U_PUT;
      FUNC_READ:  a = U_READ;
      FUNC_CLEAR: a = U_CLR;
      FUNC_NONE:  a = U_DONE;
      default:    a = U_DONE;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[hdl/text_console_writer.sv]
// Text console writer top level: screen store, cursor and microcoded sequencer.
// Depends on tcw_pkg for geometry, microcode codes and the microprogram.
//
// Requests arrive on the in_ channel (func, char_code, cell_index); each transfer
// yields one result transfer on the out_ channel with the cursor after the request
// and, for a read, the cell's character and attribute (zero otherwise and for a cell
// index beyond the screen). cfg_write/cfg_data set the attribute; the user must use
// them only while idle, as the block itself does not enforce this.
// A microprogram steps through each request, one control word per cycle. An unused
// code goes straight to the final step; a character in the last column continues as
// a newline, and a backspace at the origin writes nothing. A scroll copies the rows
// up, reading then writing each cell, and blanks the bottom row; a clear blanks every
// cell. in_ready returns with out_valid.
//
// After rst a clearing pass writes spaces in attribute 7 while in_ready stays low;
// configuration writes are taken meanwhile and the cursor homes at once. A result
// waits in an output register; the next request is still accepted and is held at
// its final step until the receiver takes the earlier result.
`default_nettype none

module text_console_writer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                func,
  input  wire logic [tcw_pkg::BYTE_W-1:0] char_code,
  input  wire logic [tcw_pkg::ADDR_W-1:0] cell_index,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [tcw_pkg::COL_W-1:0]      cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]      cursor_row,
  output logic [tcw_pkg::ADDR_W-1:0]     cursor_pos,
  output logic [tcw_pkg::BYTE_W-1:0]     read_char,
  output logic [tcw_pkg::BYTE_W-1:0]     read_attr,
  input  wire logic                      cfg_write,
  input  wire logic [tcw_pkg::BYTE_W-1:0] cfg_data
);

  localparam int CELL_COUNT = tcw_pkg::CELL_COUNT;
  localparam int ADDR_W     = tcw_pkg::ADDR_W;
  localparam int COL_W      = tcw_pkg::COL_W;
  localparam int ROW_W      = tcw_pkg::ROW_W;
  localparam int CELL_W     = tcw_pkg::CELL_W;
  localparam int BYTE_W     = tcw_pkg::BYTE_W;
  localparam int UPC_W      = tcw_pkg::UPC_W;

  // Sequencer and datapath registers
  logic [UPC_W-1:0]  upc, upc_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [BYTE_W-1:0] text_attribute;

  // Request latched at the transfer
  logic [1:0]        req_func;
  logic [BYTE_W-1:0] req_char;
  logic [ADDR_W-1:0] req_index;
  logic              req_hit;

  // Screen memory: attribute in the high byte, character in the low byte
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  tcw_pkg::ucode_t   uw;
  logic              in_fire;
  logic              out_blocked;
  logic              load_now;
  logic              cond_true;
  logic [ADDR_W-1:0] cur_addr;
  logic              idx_in_range;

  assign uw           = tcw_pkg::ucode_rom(upc);
  assign in_ready     = (upc == tcw_pkg::U_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_blocked  = out_valid && !out_ready;
  assign load_now     = uw.out_load && !out_blocked;
  assign cur_addr     = ADDR_W'(cur_row) * ADDR_W'(tcw_pkg::COLUMNS) + ADDR_W'(cur_col);
  assign idx_in_range = (req_index < ADDR_W'(CELL_COUNT));

  // Jump conditions
  always_comb begin
    unique case (uw.cond)
      tcw_pkg::J_NEXT:          cond_true = 1'b0;
      tcw_pkg::J_ALWAYS:        cond_true = 1'b1;
      tcw_pkg::J_ACCEPT:        cond_true = 1'b1;
      tcw_pkg::J_WAIT_OUT:      cond_true = 1'b1;
      tcw_pkg::J_IF_NL:         cond_true = (req_char == tcw_pkg::CH_NEWLINE) ||
                                            (req_char == tcw_pkg::CH_RETURN);
      tcw_pkg::J_IF_BS:         cond_true = (req_char == tcw_pkg::CH_BACKSPACE);
      tcw_pkg::J_IF_NOT_LAST:   cond_true = (cur_col != COL_W'(tcw_pkg::COLUMNS - 1));
      tcw_pkg::J_IF_NOT_BOT:    cond_true = (cur_row != ROW_W'(tcw_pkg::ROWS - 1));
      tcw_pkg::J_IF_COPY_MORE:  cond_true = (cnt != ADDR_W'(CELL_COUNT - tcw_pkg::COLUMNS - 1));
      tcw_pkg::J_IF_SWEEP_MORE: cond_true = (cnt != ADDR_W'(CELL_COUNT - 1));
      tcw_pkg::J_IF_ORIGIN:     cond_true = (cur_col == '0) && (cur_row == '0);
      default:                  cond_true = 1'b0;
    endcase
  end

  // Step counter: idle waits for a transfer and dispatches on the request code,
  // the final step waits for the result register to free up.
  always_comb begin
    priority if (uw.cond == tcw_pkg::J_ACCEPT) begin
      upc_next = in_fire ? tcw_pkg::dispatch(func) : upc;
    end else if (uw.cond == tcw_pkg::J_WAIT_OUT) begin
      upc_next = out_blocked ? upc : uw.target;
    end else if (cond_true) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  // Sweep counter
  always_comb begin
    unique case (uw.cnt_op)
      tcw_pkg::CNT_HOLD:  cnt_next = cnt;
      tcw_pkg::CNT_CLEAR: cnt_next = '0;
      tcw_pkg::CNT_INC:   cnt_next = cnt + ADDR_W'(1);
      default:            cnt_next = cnt;
    endcase
  end

  // Cursor moves
  always_comb begin
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    unique case (uw.cur_op)
      tcw_pkg::CUR_NONE: begin
      end
      tcw_pkg::CUR_HOME: begin
        cur_col_next = '0;
        cur_row_next = '0;
      end
      tcw_pkg::CUR_INC: begin
        cur_col_next = cur_col + COL_W'(1);
      end
      tcw_pkg::CUR_NEXT_ROW: begin
        cur_col_next = '0;
        cur_row_next = cur_row + ROW_W'(1);
      end
      tcw_pkg::CUR_COL0: begin
        cur_col_next = '0;
      end
      tcw_pkg::CUR_BACK: begin
        // Stepping back from the first column wraps to the end of the row above.
        if (cur_col == '0) begin
          cur_col_next = COL_W'(tcw_pkg::COLUMNS - 1);
          cur_row_next = cur_row - ROW_W'(1);
        end else begin
          cur_col_next = cur_col - COL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Memory write port
  always_comb begin
    mem_we  = 1'b1;
    wr_addr = cnt;
    wr_data = {text_attribute, tcw_pkg::CH_SPACE};
    unique case (uw.mem_op)
      tcw_pkg::MW_NONE: begin
        mem_we = 1'b0;
      end
      tcw_pkg::MW_CHAR_CUR: begin
        wr_addr = cur_addr;
        wr_data = {text_attribute, req_char};
      end
      tcw_pkg::MW_SPACE_CUR: begin
        wr_addr = cur_addr;
      end
      tcw_pkg::MW_COPY_CNT: begin
        // The character comes from the row below; the attribute is the current one.
        wr_data = {text_attribute, rdata[BYTE_W-1:0]};
      end
      tcw_pkg::MW_BLANK_CNT: begin
      end
      tcw_pkg::MW_RESET_CNT: begin
        wr_data = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Memory read port
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (uw.rd_op)
      tcw_pkg::RD_NONE:    rd_en = 1'b0;
      tcw_pkg::RD_INDEX:   rd_addr = idx_in_range ? req_index : '0;
      tcw_pkg::RD_CNT_ROW: rd_addr = cnt + ADDR_W'(tcw_pkg::COLUMNS);
      default:             rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= screen_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc            <= tcw_pkg::U_RST;
      cnt            <= '0;
      cur_col        <= '0;
      cur_row        <= '0;
      text_attribute <= tcw_pkg::RESET_ATTR;
      out_valid      <= 1'b0;
    end else begin
      upc     <= upc_next;
      cnt     <= cnt_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      if (cfg_write) begin
        text_attribute <= cfg_data;
      end
      if (load_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func  <= func;
      req_char  <= char_code;
      req_index <= cell_index;
    end
    if (load_now) begin
      cursor_col <= cur_col;
      cursor_row <= cur_row;
      cursor_pos <= cur_addr;
      read_char  <= req_hit ? rdata[BYTE_W-1:0] : '0;
      read_attr  <= req_hit ? rdata[CELL_W-1:BYTE_W] : '0;
    end
  end

  assign req_hit = (req_func == tcw_pkg::FUNC_READ) && idx_in_range;

  // Checks
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(tcw_pkg::COLUMNS)) && (cur_row < ROW_W'(tcw_pkg::ROWS)))
    else $error("cursor left the screen");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (wr_addr < ADDR_W'(CELL_COUNT)))
    else $error("screen write beyond the store");

  a_pos_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_pos == ADDR_W'(cursor_row) * ADDR_W'(tcw_pkg::COLUMNS)
                                 + ADDR_W'(cursor_col)))
    else $error("cursor position disagrees with row and column");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(upc) == tcw_pkg::U_DONE))
    else $error("result raised outside the final step");

endmodule

`default_nettype wire

[tb/console_checker.sv]
// Checker for the text console writer: mirrors the screen, cursor and text attribute,
// predicts every result from the accepted requests and compares it with the block.
// Depends on tcw_pkg for the screen geometry and the request and character codes.
module console_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        func,
  input  logic [BYTE_W-1:0] char_code,
  input  logic [ADDR_W-1:0] cell_index,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [COL_W-1:0]  cursor_col,
  input  logic [ROW_W-1:0]  cursor_row,
  input  logic [ADDR_W-1:0] cursor_pos,
  input  logic [BYTE_W-1:0] read_char,
  input  logic [BYTE_W-1:0] read_attr,
  input  logic              cfg_write,
  input  logic [BYTE_W-1:0] cfg_data,
  output int                results_owed,
  output int                mismatch_count
);

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] pos;
    logic [BYTE_W-1:0] rch;
    logic [BYTE_W-1:0] rattr;
  } console_result_t;

  // Each cell holds the attribute in the high byte and the character in the low byte.
  logic [CELL_W-1:0] screen [CELL_COUNT];
  int unsigned       cur_r;
  int unsigned       cur_c;
  logic [BYTE_W-1:0] text_attr;
  console_result_t   owed_q [$];
  int                fails = 0;

  function void fill_screen(input logic [BYTE_W-1:0] attr);
    int i;
    for (i = 0; i < CELL_COUNT; i++) screen[i] = {attr, CH_SPACE};
    cur_r = 0;
    cur_c = 0;
  endfunction

  // Scrolling keeps the characters but recolours every moved cell.
  function void scroll_screen();
    int i;
    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
      screen[i] = {text_attr, screen[i + COLUMNS][BYTE_W-1:0]};
    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = {text_attr, CH_SPACE};
  endfunction

  function void line_feed();
    if (cur_r >= ROWS - 1) begin
      cur_r = ROWS - 1;
      scroll_screen();
    end else begin
      cur_r++;
    end
    cur_c = 0;
  endfunction

  function void put_char(input logic [BYTE_W-1:0] ch);
    if (ch == CH_NEWLINE || ch == CH_RETURN) begin
      line_feed();
    end else if (ch == CH_BACKSPACE) begin
      if (cur_c != 0 || cur_r != 0) begin
        if (cur_c == 0) begin
          cur_c = COLUMNS - 1;
          cur_r--;
        end else begin
          cur_c--;
        end
        screen[cur_r * COLUMNS + cur_c] = {text_attr, CH_SPACE};
      end
    end else begin
      screen[cur_r * COLUMNS + cur_c] = {text_attr, ch};
      if (cur_c >= COLUMNS - 1) line_feed();
      else cur_c++;
    end
  endfunction

  function console_result_t console_step(input logic [1:0] f, input logic [BYTE_W-1:0] ch,
                                         input logic [ADDR_W-1:0] idx);
    console_result_t r;
    r = '0;
    case (f)
      FUNC_PUT: put_char(ch);
      FUNC_READ: begin
        if (idx < CELL_COUNT) begin
          r.rch   = screen[idx][BYTE_W-1:0];
          r.rattr = screen[idx][CELL_W-1:BYTE_W];
        end
      end
      FUNC_CLEAR: fill_screen(text_attr);
      default: ;
    endcase
    r.col = COL_W'(cur_c);
    r.row = ROW_W'(cur_r);
    r.pos = ADDR_W'(cur_r * COLUMNS + cur_c);
    return r;
  endfunction

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst) begin
      text_attr = RESET_ATTR;
      fill_screen(RESET_ATTR);
      owed_q.delete();
    end else begin
      if (cfg_write) text_attr = cfg_data;
      // Results are matched before a new request is queued in the same cycle.
      if (out_valid && out_ready) begin
        got = {cursor_col, cursor_row, cursor_pos, read_char, read_attr};
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with none expected: col %0d row %0d pos %0d char %h attr %h",
                     $time, got.col, got.row, got.pos, got.rch, got.rattr);
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: result mismatch, expected col %0d row %0d pos %0d char %h attr %h",
                       $time, want.col, want.row, want.pos, want.rch, want.rattr);
              $display("%0t:                    got col %0d row %0d pos %0d char %h attr %h",
                       $time, got.col, got.row, got.pos, got.rch, got.rattr);
            end
          end
        end
      end
      if (in_valid && in_ready) owed_q.push_back(console_step(func, char_code, cell_index));
    end
    results_owed   <= owed_q.size();
    mismatch_count <= fails;
  end

endmodule

[tb/tb.sv]
// Top of the text console writer testbench: clock, reset, request and result traffic,
// attribute writes, watchdog and verdict.
// Depends on tcw_pkg, the text_console_writer block and the console_checker module.
module tb;
  import tcw_pkg::*;

  // A scroll copies the whole screen and the reset pass sweeps every cell, so these
  // make the longest quiet stretches of a healthy block.
  localparam int WATCHDOG_LIMIT = 40000;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 260;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [1:0]        func       = FUNC_PUT;
  logic [BYTE_W-1:0] char_code  = '0;
  logic [ADDR_W-1:0] cell_index = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] cursor_pos;
  logic [BYTE_W-1:0] read_char;
  logic [BYTE_W-1:0] read_attr;
  logic              cfg_write  = 1'b0;
  logic [BYTE_W-1:0] cfg_data   = '0;

  int results_owed;
  int mismatch_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;
  int hold_count     = 0;
  bit hold_phase     = 1'b0;

  always #6 clk = ~clk;

  text_console_writer u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .char_code  (char_code),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cursor_pos (cursor_pos),
    .read_char  (read_char),
    .read_attr  (read_attr),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data)
  );

  console_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .char_code      (char_code),
    .cell_index     (cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cursor_pos     (cursor_pos),
    .read_char      (read_char),
    .read_attr      (read_attr),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  // The receiver stalls at random. While a hold phase is requested it first keeps
  // ready low for a counted stretch, so that the output register and the held
  // request fill up and the block stops taking transfers on its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
    end else if (hold_phase && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_phase) hold_count <= 0;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst) quiet_cycles <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Offers one request, with random idle cycles beforehand, and returns in the time
  // step of the edge at which the transfer took place. Valid is left high so that
  // back-to-back requests need no second assignment in the same step.
  task automatic send_item(input logic [1:0] f, input logic [BYTE_W-1:0] ch,
                           input logic [ADDR_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    char_code  <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Withdraws valid and waits until every predicted result has been taken. The
  // checker's count is registered, hence the wait before the first look.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic set_text_attribute(input logic [BYTE_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] any_index();
    return ADDR_W'($urandom_range(2047));
  endfunction

  // Mostly printable text, now and then any byte at all, control codes included.
  function automatic logic [BYTE_W-1:0] text_byte();
    if ($urandom_range(9) == 0) return BYTE_W'($urandom_range(255));
    return BYTE_W'($urandom_range(126, 32));
  endfunction

  // Reads favour the left part of each row, where most of the text lands; a quarter
  // go anywhere in the index range, beyond the screen too.
  function automatic logic [ADDR_W-1:0] read_target();
    if ($urandom_range(3) == 0) return any_index();
    return ADDR_W'($urandom_range(ROWS - 1) * COLUMNS + $urandom_range(23));
  endfunction

  // One burst of console traffic. Lines of text ended by a newline make up most of
  // it, so that the cursor works its way down to the bottom row and scrolls; long
  // lines wrap at the last column. Backspace runs, reads, the odd clear and random
  // noise (unused request code included) make up the rest.
  task automatic random_episode();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 50) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(COLUMNS + 5, COLUMNS - 5)
                                   : $urandom_range(8);
      repeat (n) send_item(FUNC_PUT, text_byte(), any_index());
      // Now and then the line is left unterminated.
      if ($urandom_range(7) != 0)
        send_item(FUNC_PUT, $urandom_range(1) ? CH_NEWLINE : CH_RETURN, any_index());
    end else if (kind < 64) begin
      // Occasional long runs step back across rows and pile up at the origin.
      n = ($urandom_range(9) == 0) ? $urandom_range(2 * COLUMNS, COLUMNS)
                                   : $urandom_range(6, 1);
      repeat (n) send_item(FUNC_PUT, CH_BACKSPACE, any_index());
    end else if (kind < 86) begin
      repeat ($urandom_range(4, 1))
        send_item(FUNC_READ, BYTE_W'($urandom_range(255)), read_target());
    end else if (kind < 87) begin
      send_item(FUNC_CLEAR, BYTE_W'($urandom_range(255)), any_index());
    end else begin
      repeat ($urandom_range(3, 1))
        send_item(2'($urandom_range(3)), BYTE_W'($urandom_range(255)), any_index());
    end
  endtask

  // A phase starts from an idle block: all results in, then a new attribute and a
  // new idling pattern. The optional long hold comes first.
  task automatic run_phase(input logic [BYTE_W-1:0] attr, input int sender_idle,
                           input int receiver_stall, input bit long_hold);
    int target;
    drain_results();
    set_text_attribute(attr);
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    if (long_hold) begin
      hold_phase <= 1'b1;
      repeat (12) send_item(FUNC_PUT, text_byte(), any_index());
      hold_phase <= 1'b0;
    end
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) random_episode();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, in the reset attribute. The block is busy with its clearing
    // pass at first, so the first transfer simply waits for it.
    send_item(FUNC_READ, 8'hFF, 11'd0);                    // reset content
    send_item(FUNC_READ, 8'h00, ADDR_W'(CELL_COUNT - 1));  // last cell
    send_item(FUNC_READ, 8'h5A, ADDR_W'(CELL_COUNT));      // just beyond the screen
    send_item(FUNC_READ, 8'hA5, 11'h7FF);                  // top of the index range
    send_item(FUNC_PUT, CH_BACKSPACE, any_index());        // backspace at the origin
    send_item(FUNC_PUT, 8'h41, 11'h7FF);
    send_item(FUNC_PUT, 8'h00, any_index());
    send_item(FUNC_PUT, 8'hFF, any_index());
    send_item(FUNC_PUT, CH_BACKSPACE, any_index());        // blanks the 0xFF cell
    send_item(FUNC_READ, 8'h00, 11'd2);
    send_item(FUNC_PUT, CH_RETURN, any_index());
    send_item(FUNC_PUT, CH_BACKSPACE, any_index());        // wraps to the row above
    send_item(FUNC_PUT, 8'h5A, any_index());               // last column, then next row
    send_item(FUNC_PUT, CH_NEWLINE, any_index());
    send_item(FUNC_NONE, 8'hFF, 11'h7FF);                  // unused code is ignored
    send_item(FUNC_READ, 8'h00, ADDR_W'(COLUMNS - 1));
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_CLEAR, 8'hFF, 11'h7FF);
    send_item(FUNC_READ, 8'h00, 11'd0);
    send_item(FUNC_READ, 8'h00, ADDR_W'(COLUMNS));
    send_item(FUNC_PUT, CH_NEWLINE, 11'd0);

    // Random part: extremes of the attribute first, then random values, each under
    // its own idling pattern.
    run_phase(8'h00, 0, 0, 1'b0);
    run_phase(8'hFF, 73, 0, 1'b0);
    run_phase(BYTE_W'($urandom_range(255)), 0, 73, 1'b1);
    run_phase(BYTE_W'($urandom_range(255)), 26, 26, 1'b0);

    drain_results();
    // A little longer, in case the block produces a stray extra result.
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[text_console_writer.f]
hdl/tcw_pkg.sv
hdl/text_console_writer.sv
tb/console_checker.sv
tb/tb.sv
